// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the key-value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define KVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kvt_pkg.sv =====
// Types, codes and default sizes shared by the key-value table files.
`default_nettype none

package kvt_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned USED_W   = 7;

  // Default sizes of the table.
  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned KEY_BITS_DEF = 16;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_PREFIX = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_MISS     = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  // Payload of one request.
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [KEY_W-1:0]  key_a;
    logic signed [KEY_W-1:0]  key_b;
    logic signed [KEY_W-1:0]  key_c;
    logic signed [KEY_W-1:0]  key_d;
    logic [VALUE_W-1:0]       new_value;
  } req_t;

  // Payload of one result.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [VALUE_W-1:0]       value_out;
    logic signed [KEY_W-1:0]  found_c;
    logic signed [KEY_W-1:0]  found_d;
    logic [POS_W-1:0]         run_first;
    logic [POS_W-1:0]         run_last;
    logic [USED_W-1:0]        entries_used;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/kvt_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the key-value table.
`default_nettype none

interface kvt_req_if;
  import kvt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kvt_rsp_if;
  import kvt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/four_key_value_table.sv =====
// Top level of the four-part key to value table.
//
// Requests arrive on in_ch and one result leaves on out_ch for each request; a
// transfer takes place on a clock edge where valid and ready are both high.
// Entries sit in one synchronous memory in insertion order, packed from position
// zero, and a sequencer walks it one entry per cycle through the single read port.
// A request is taken only in the idle state; a lookup stops at the entry that hits,
// a miss walks every held entry, and a removal goes on to move the entries above
// the hole down one per cycle. The next request is taken as soon as the
// sequencer is idle again, so the rate is set by the scan of the memory, which
// walks every entry on a full table.
// The result register parts the two sides: a new request may be taken while a
// result waits, and a finished result is held in the sequencer until the
// receiver has taken the previous one. Reset empties the table (the entry count
// goes to zero, the memory is left as it is) and drops any pending result.
`default_nettype none

module four_key_value_table #(
  parameter int unsigned ENTRIES  = kvt_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = kvt_pkg::KEY_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  kvt_req_if.sink    in_ch,
  kvt_rsp_if.source  out_ch
);
  import kvt_pkg::*;

  // Stored width of one key part, index width and count width.
  localparam int unsigned KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef struct packed {
    logic [KB-1:0]      a;
    logic [KB-1:0]      b;
    logic [KB-1:0]      c;
    logic [KB-1:0]      d;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Entry memory and its registered read port.
  entry_t        entry_mem [ENTRIES];
  entry_t        rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  // Control state.
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Request and working registers.
  mode_t              mode_r, mode_nxt;
  logic [KB-1:0]      ka_r, ka_nxt, kb_r, kb_nxt, kc_r, kc_nxt, kd_r, kd_nxt;
  logic [VALUE_W-1:0] nv_r, nv_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] vout_r, vout_nxt;
  logic [KB-1:0]      fc_r, fc_nxt, fd_r, fd_nxt;
  logic [IW-1:0]      first_r, first_nxt, last_r, last_nxt;
  rsp_t               out_data_r, out_data_nxt;

  logic in_ready;
  logic pre_hit;
  logic key_hit;
  logic is_last;
  logic match;

  // Compare the entry on the read port against the held key.
  assign pre_hit = (rd_data_r.a == ka_r) && (rd_data_r.b == kb_r);
  assign key_hit = pre_hit && (rd_data_r.c == kc_r) && (rd_data_r.d == kd_r);
  assign is_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign match   = (mode_r == MODE_PREFIX) ? pre_hit : key_hit;

  // Next state, memory accesses and result fields.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mode_nxt      = mode_r;
    ka_nxt        = ka_r;
    kb_nxt        = kb_r;
    kc_nxt        = kc_r;
    kd_nxt        = kd_r;
    nv_nxt        = nv_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    fc_nxt        = fc_r;
    fd_nxt        = fd_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    in_ready      = 1'b0;
    rd_addr       = idx_r + IW'(1);
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
        if (in_ch.valid) begin
          mode_nxt   = mode_t'(in_ch.data.mode);
          ka_nxt     = in_ch.data.key_a[KB-1:0];
          kb_nxt     = in_ch.data.key_b[KB-1:0];
          kc_nxt     = in_ch.data.key_c[KB-1:0];
          kd_nxt     = in_ch.data.key_d[KB-1:0];
          nv_nxt     = in_ch.data.new_value;
          idx_nxt    = '0;
          status_nxt = STAT_MISS;
          vout_nxt   = '0;
          fc_nxt     = '0;
          fd_nxt     = '0;
          first_nxt  = '0;
          last_nxt   = '0;
          if (count_r == '0) begin
            // Empty table: a put lands at position zero, anything else misses.
            if (mode_t'(in_ch.data.mode) == MODE_PUT) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_data    = '{a: in_ch.data.key_a[KB-1:0], b: in_ch.data.key_b[KB-1:0],
                             c: in_ch.data.key_c[KB-1:0], d: in_ch.data.key_d[KB-1:0],
                             value: in_ch.data.new_value};
              count_nxt  = CW'(1);
              status_nxt = STAT_INSERTED;
            end
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (match) begin
          vout_nxt = rd_data_r.value;
          unique case (mode_r)
            MODE_PUT: begin
              // Rewrite the hit entry with the new value.
              wr_en         = 1'b1;
              wr_data.value = nv_r;
              status_nxt    = STAT_UPDATED;
              state_nxt     = ST_EMIT;
            end
            MODE_GET: begin
              status_nxt = STAT_FOUND;
              state_nxt  = ST_EMIT;
            end
            MODE_REMOVE: begin
              status_nxt = STAT_FOUND;
              if (is_last) begin
                count_nxt = count_r - CW'(1);
                state_nxt = ST_EMIT;
              end else begin
                idx_nxt   = idx_r + IW'(1);
                state_nxt = ST_SHIFT;
              end
            end
            MODE_PREFIX: begin
              status_nxt = STAT_FOUND;
              fc_nxt     = rd_data_r.c;
              fd_nxt     = rd_data_r.d;
              first_nxt  = idx_r;
              last_nxt   = idx_r;
              if (is_last) begin
                state_nxt = ST_EMIT;
              end else begin
                idx_nxt   = idx_r + IW'(1);
                state_nxt = ST_RUN;
              end
            end
            default: state_nxt = ST_EMIT;
          endcase
        end else if (is_last) begin
          // Scan ran off the held entries: append on put if there is room.
          if (mode_r == MODE_PUT) begin
            if (count_r < FULL_COUNT) begin
              wr_en      = 1'b1;
              wr_addr    = IW'(count_r);
              wr_data    = '{a: ka_r, b: kb_r, c: kc_r, d: kd_r, value: nv_r};
              count_nxt  = count_r + CW'(1);
              status_nxt = STAT_INSERTED;
            end else begin
              status_nxt = STAT_FULL;
            end
          end
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_RUN: begin
        // Extend the run while the prefix keeps matching.
        if (pre_hit) begin
          last_nxt = idx_r;
          if (is_last) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_SHIFT: begin
        // Move each later entry down one position to close the gap.
        wr_en   = 1'b1;
        wr_addr = idx_r - IW'(1);
        if (is_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_EMIT: begin
        // Load the result register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.value_out    = vout_r;
          out_data_nxt.found_c      = KEY_W'(fc_r);
          out_data_nxt.found_d      = KEY_W'(fd_r);
          out_data_nxt.run_first    = POS_W'(first_r);
          out_data_nxt.run_last     = POS_W'(last_r);
          out_data_nxt.entries_used = USED_W'(count_r);
          state_nxt                 = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    ka_r       <= ka_nxt;
    kb_r       <= kb_nxt;
    kc_r       <= kc_nxt;
    kd_r       <= kd_nxt;
    nv_r       <= nv_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    vout_r     <= vout_nxt;
    fc_r       <= fc_nxt;
    fd_r       <= fd_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/kvt_checker.sv =====
// Port-level checks on the key-value table and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module kvt_checker #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input wire kvt_pkg::rsp_t out_data
);
  import kvt_pkg::*;

  localparam logic [USED_W-1:0] FULL_USED = USED_W'(ENTRIES);

  logic side_zero;
  logic is_miss_or_full;

  // Prefix fields are only meaningful on a found result.
  assign side_zero = (out_data.found_c == '0) && (out_data.found_d == '0) &&
                     (out_data.run_first == '0) && (out_data.run_last == '0);
  assign is_miss_or_full = (out_data.status == STAT_MISS) ||
                           (out_data.status == STAT_FULL);

  // A stalled result stays put until the receiver takes it.
  `KVT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Anything other than a found result leaves the prefix fields at zero.
  `KVT_ASSERT_IMPLY(a_side_zero, clk, rst_n, out_valid && (out_data.status != STAT_FOUND), side_zero, "prefix fields set on a non-found result")

  // Misses and full-table refusals return a zero value.
  `KVT_ASSERT_IMPLY(a_miss_value, clk, rst_n, out_valid && is_miss_or_full, out_data.value_out == '0, "value returned on a miss")

  // A full-table refusal is only reported with every entry in use.
  `KVT_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (out_data.status == STAT_FULL), out_data.entries_used == FULL_USED, "table full reported below capacity")

endmodule

bind four_key_value_table kvt_checker #(.ENTRIES(ENTRIES)) u_kvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the four-part key to value table.
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import kvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  // One row of the directed stimulus, with an optional hand-written result.
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  kvt_req_if in_if ();
  kvt_rsp_if out_if ();

  four_key_value_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Shadow copy of the table: keys packed as {a, b, c, d}, in insertion order.
  logic [4*KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
  logic [VALUE_W-1:0]   shadow_values [TABLE_DEPTH];
  int unsigned          shadow_used;

  rsp_t        pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  bit          hold_request;

  logic [KEY_W-1:0] key_pool [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every mismatch goes through here so that it is printed and counted.
  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Work out the result of one request and update the shadow table.
  function automatic rsp_t table_apply(req_t r);
    rsp_t               res;
    logic [4*KEY_W-1:0] key;
    int                 hit;
    int unsigned        last;
    res = '0;
    res.status = STAT_MISS;
    key = {r.key_a, r.key_b, r.key_c, r.key_d};
    hit = -1;
    if (mode_t'(r.mode) == MODE_PREFIX) begin
      for (int i = 0; i < shadow_used; i++) begin
        if (hit < 0 && shadow_keys[i][4*KEY_W-1:2*KEY_W] == key[4*KEY_W-1:2*KEY_W]) hit = i;
      end
    end else begin
      for (int i = 0; i < shadow_used; i++) begin
        if (hit < 0 && shadow_keys[i] == key) hit = i;
      end
    end
    case (mode_t'(r.mode))
      MODE_PUT: begin
        if (hit >= 0) begin
          res.value_out = shadow_values[hit];
          shadow_values[hit] = r.new_value;
          res.status = STAT_UPDATED;
        end else if (shadow_used < TABLE_DEPTH) begin
          shadow_keys[shadow_used] = key;
          shadow_values[shadow_used] = r.new_value;
          shadow_used++;
          res.status = STAT_INSERTED;
        end else begin
          res.status = STAT_FULL;
        end
      end
      MODE_GET: begin
        if (hit >= 0) begin
          res.value_out = shadow_values[hit];
          res.status = STAT_FOUND;
        end
      end
      MODE_REMOVE: begin
        if (hit >= 0) begin
          res.value_out = shadow_values[hit];
          // Close the gap: later entries move down one position.
          for (int i = hit; i + 1 < shadow_used; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_used--;
          res.status = STAT_FOUND;
        end
      end
      default: begin
        if (hit >= 0) begin
          // Walk the contiguous run sharing the prefix, stopping at the end.
          last = hit;
          while (last + 1 < shadow_used &&
                 shadow_keys[last+1][4*KEY_W-1:2*KEY_W] == key[4*KEY_W-1:2*KEY_W])
            last++;
          res.status = STAT_FOUND;
          res.value_out = shadow_values[hit];
          res.found_c = shadow_keys[hit][2*KEY_W-1:KEY_W];
          res.found_d = shadow_keys[hit][KEY_W-1:0];
          res.run_first = POS_W'(hit);
          res.run_last = POS_W'(last);
        end
      end
    endcase
    res.entries_used = USED_W'(shadow_used);
    return res;
  endfunction

  // Compare one transferred result with the oldest expectation.
  task automatic check_result(rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing pending", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.value_out !== want.value_out)
      report_mismatch($sformatf("value_out %h, expected %h", got.value_out, want.value_out));
    if (got.found_c !== want.found_c)
      report_mismatch($sformatf("found_c %h, expected %h", got.found_c, want.found_c));
    if (got.found_d !== want.found_d)
      report_mismatch($sformatf("found_d %h, expected %h", got.found_d, want.found_d));
    if (got.run_first !== want.run_first)
      report_mismatch($sformatf("run_first %0d, expected %0d", got.run_first, want.run_first));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %0d, expected %0d", got.run_last, want.run_last));
    if (got.entries_used !== want.entries_used)
      report_mismatch($sformatf("entries_used %0d, expected %0d",
                                got.entries_used, want.entries_used));
  endtask

  // Result monitor: check each transfer on the result channel.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result(out_if.data);
  end

  // Offer one request and record its expected result once it is transferred.
  task automatic send_request(req_t r, bit typed, rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data <= r;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    predicted = table_apply(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold the request channel quiet until every expected result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic req_t make_req(mode_t m, int a, int b, int c, int d,
                                    logic [VALUE_W-1:0] v);
    req_t r;
    r.mode = m;
    r.key_a = a[KEY_W-1:0];
    r.key_b = b[KEY_W-1:0];
    r.key_c = c[KEY_W-1:0];
    r.key_d = d[KEY_W-1:0];
    r.new_value = v;
    return r;
  endfunction

  function automatic rsp_t make_rsp(status_t s, logic [VALUE_W-1:0] v, int used);
    rsp_t res;
    res = '0;
    res.status = s;
    res.value_out = v;
    res.entries_used = USED_W'(used);
    return res;
  endfunction

  // Key part: mostly from a small pool so that hits and prefix runs are common.
  function automatic logic [KEY_W-1:0] pick_part(int unsigned pool_size);
    if ($urandom_range(99) < 10) return KEY_W'($urandom);
    return key_pool[$urandom_range(pool_size - 1)];
  endfunction

  // Random request; while filling, puts dominate so that the table runs full.
  function automatic req_t random_req(bit filling);
    req_t        r;
    int unsigned w;
    w = $urandom_range(99);
    if (filling)
      r.mode = (w < 80) ? MODE_PUT : (w < 87) ? MODE_GET : (w < 93) ? MODE_REMOVE : MODE_PREFIX;
    else
      r.mode = (w < 35) ? MODE_PUT : (w < 55) ? MODE_GET : (w < 80) ? MODE_REMOVE : MODE_PREFIX;
    r.key_a = pick_part(3);
    r.key_b = pick_part(3);
    r.key_c = pick_part(4);
    r.key_d = pick_part(4);
    r.new_value = $urandom;
    return r;
  endfunction

  // Main sequence.
  initial begin
    rsp_t blank;
    blank = '0;
    error_count = 0;
    cycle_count = 0;
    shadow_used = 0;
    hold_left = 0;
    hold_request = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 85;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;

    // Directed rows: empty table, extremes, update, removal and prefix runs.
    directed_rows.push_back('{make_req(MODE_GET, 1, 2, 3, 4, 0), 1,
                              make_rsp(STAT_MISS, 0, 0)});
    directed_rows.push_back('{make_req(MODE_PREFIX, 1, 2, 0, 0, 0), 1,
                              make_rsp(STAT_MISS, 0, 0)});
    directed_rows.push_back('{make_req(MODE_REMOVE, 1, 2, 3, 4, 0), 1,
                              make_rsp(STAT_MISS, 0, 0)});
    directed_rows.push_back('{make_req(MODE_PUT, -32768, -32768, -32768, -32768, 0), 1,
                              make_rsp(STAT_INSERTED, 0, 1)});
    directed_rows.push_back('{make_req(MODE_PUT, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF), 1,
                              make_rsp(STAT_INSERTED, 0, 2)});
    directed_rows.push_back('{make_req(MODE_PUT, -1, 0, -1, 0, 32'hA5A5_5A5A), 1,
                              make_rsp(STAT_INSERTED, 0, 3)});
    directed_rows.push_back('{make_req(MODE_PUT, -1, 0, 5, 6, 32'h0000_1234), 1,
                              make_rsp(STAT_INSERTED, 0, 4)});
    directed_rows.push_back('{make_req(MODE_PUT, -1, 0, -1, 0, 32'h3F80_0000), 1,
                              make_rsp(STAT_UPDATED, 32'hA5A5_5A5A, 4)});
    directed_rows.push_back('{make_req(MODE_GET, 32767, 32767, 32767, 32767, 0), 1,
                              make_rsp(STAT_FOUND, 32'hFFFF_FFFF, 4)});
    // Differs from a stored key in the last part only.
    directed_rows.push_back('{make_req(MODE_GET, 32767, 32767, 32767, -32768, 0), 1,
                              make_rsp(STAT_MISS, 0, 4)});
    directed_rows.push_back('{make_req(MODE_PREFIX, -1, 0, 0, 0, 0), 0, blank});
    directed_rows.push_back('{make_req(MODE_PUT, -32768, -32768, 1, 1, 7), 0, blank});
    directed_rows.push_back('{make_req(MODE_PREFIX, -32768, -32768, 0, 0, 0), 0, blank});
    directed_rows.push_back('{make_req(MODE_PUT, 32767, 32767, 0, 0, 9), 0, blank});
    directed_rows.push_back('{make_req(MODE_PREFIX, 32767, 32767, 1, 1, 0), 0, blank});
    directed_rows.push_back('{make_req(MODE_REMOVE, -1, 0, -1, 0, 0), 1,
                              make_rsp(STAT_FOUND, 32'h3F80_0000, 5)});
    directed_rows.push_back('{make_req(MODE_PREFIX, -1, 0, 0, 0, 0), 0, blank});
    // Removal of the last entry.
    directed_rows.push_back('{make_req(MODE_REMOVE, 32767, 32767, 0, 0, 0), 1,
                              make_rsp(STAT_FOUND, 9, 4)});
    directed_rows.push_back('{make_req(MODE_PUT, -32768, -32768, 2, 2, 8), 0, blank});
    // Removal of the first entry.
    directed_rows.push_back('{make_req(MODE_REMOVE, -32768, -32768, -32768, -32768, 0), 1,
                              make_rsp(STAT_FOUND, 0, 4)});
    // Prefix run that reaches the end of the held entries; parts c and d ignored.
    directed_rows.push_back('{make_req(MODE_PREFIX, -32768, -32768, 123, -5, 32'hFFFF_FFFF),
                              0, blank});
    directed_rows.push_back('{make_req(MODE_REMOVE, 1, 2, 3, 4, 0), 1,
                              make_rsp(STAT_MISS, 0, 4)});
    directed_rows.push_back('{make_req(MODE_GET, -1, 0, 5, 6, 0), 0, blank});

    // Reset.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    wait_for_results();

    // Random phases: sender mostly busy, then receiver mostly busy, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 33 : 0;
      // Long receiver hold-off while requests keep coming, to fill the block.
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < 250; n++) send_request(random_req(n < 140), 1'b0, blank);
      wait_for_results();
    end

    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
